### src/nps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest point search package
// Shared widths, opcodes and pipeline tag type.
// ----------------------------------------------------------------------------
package nps_pkg;

   localparam int MAX_ENTRIES = 256;
   localparam int COORD_BITS  = 24;
   localparam int ADDR_W      = $clog2(MAX_ENTRIES);
   localparam int COUNT_W     = $clog2(MAX_ENTRIES + 1);
   localparam int INDEX_W     = 8;
   localparam int DIFF_W      = COORD_BITS + 1;
   localparam int MAG_W       = COORD_BITS;
   localparam int SQ_W        = 2 * MAG_W;
   localparam int DIST_W      = 50;
   localparam int POINT_W     = 2 * COORD_BITS;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      logic              valid;
      logic              last;
      logic [ADDR_W-1:0] index;
   } dist_tag_type;

endpackage

### src/nps_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest point search channels
// Request, response and register write channels with valid/ready.
// ----------------------------------------------------------------------------
interface nps_req_if;
   logic                                valid;
   logic                                ready;
   logic                                operation;
   logic [nps_pkg::INDEX_W-1:0]         entry_index;
   logic signed [nps_pkg::COORD_BITS-1:0] pos_x;
   logic signed [nps_pkg::COORD_BITS-1:0] pos_z;

   modport source (output valid, operation, entry_index, pos_x, pos_z, input ready);
   modport sink   (input valid, operation, entry_index, pos_x, pos_z, output ready);
endinterface

interface nps_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        found;
   logic [nps_pkg::INDEX_W-1:0] nearest_index;
   logic [nps_pkg::DIST_W-1:0]  distance_squared;

   modport source (output valid, found, nearest_index, distance_squared, input ready);
   modport sink   (input valid, found, nearest_index, distance_squared, output ready);
endinterface

interface nps_csr_if;
   logic                        valid;
   logic                        ready;
   logic [nps_pkg::COUNT_W-1:0] node_count;

   modport source (output valid, node_count, input ready);
   modport sink   (input valid, node_count, output ready);
endinterface

### src/nps_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module nps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/nps_dist.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest point search distance pipeline
// Three stages: absolute difference, square, sum of squares.
// ----------------------------------------------------------------------------
module nps_dist (
   input  logic                          clock,
   input  logic                          reset,
   input  nps_pkg::dist_tag_type         tag,
   input  nps_pkg::coord_type            point_x,
   input  nps_pkg::coord_type            point_z,
   input  nps_pkg::coord_type            query_x,
   input  nps_pkg::coord_type            query_z,
   output nps_pkg::dist_tag_type         out_tag,
   output logic [nps_pkg::DIST_W-1:0]    out_dist
);

   logic signed [nps_pkg::DIFF_W-1:0] diff_x;
   logic signed [nps_pkg::DIFF_W-1:0] diff_z;

   nps_pkg::dist_tag_type tag1_ff, tag1_in, tag2_ff, tag2_in, tag3_ff, tag3_in;
   logic [nps_pkg::MAG_W-1:0]  dx_ff, dx_in, dz_ff, dz_in;
   logic [nps_pkg::SQ_W-1:0]   sqx_ff, sqx_in, sqz_ff, sqz_in;
   logic [nps_pkg::DIST_W-1:0] dist_ff, dist_in;

   always_comb begin
      diff_x = nps_pkg::DIFF_W'(point_x) - nps_pkg::DIFF_W'(query_x);
      diff_z = nps_pkg::DIFF_W'(point_z) - nps_pkg::DIFF_W'(query_z);
      dx_in  = diff_x[nps_pkg::DIFF_W-1] ? nps_pkg::MAG_W'(-diff_x)
                                         : nps_pkg::MAG_W'(diff_x);
      dz_in  = diff_z[nps_pkg::DIFF_W-1] ? nps_pkg::MAG_W'(-diff_z)
                                         : nps_pkg::MAG_W'(diff_z);
      sqx_in = nps_pkg::SQ_W'(dx_ff) * nps_pkg::SQ_W'(dx_ff);
      sqz_in = nps_pkg::SQ_W'(dz_ff) * nps_pkg::SQ_W'(dz_ff);
      dist_in = nps_pkg::DIST_W'(sqx_ff) + nps_pkg::DIST_W'(sqz_ff);
      tag1_in = tag;
      tag2_in = tag1_ff;
      tag3_in = tag2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
         tag3_ff <= '0;
      end else begin
         tag1_ff <= tag1_in;
         tag2_ff <= tag2_in;
         tag3_ff <= tag3_in;
      end
      dx_ff   <= dx_in;
      dz_ff   <= dz_in;
      sqx_ff  <= sqx_in;
      sqz_ff  <= sqz_in;
      dist_ff <= dist_in;
   end

   assign out_tag  = tag3_ff;
   assign out_dist = dist_ff;

endmodule

### src/nearest_point_search_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest point search
// Point table in RAM, linear scan for the entry nearest to a query point.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch  : request beats. operation LOAD writes (pos_x, pos_z) into slot
//             entry_index and returns nothing. QUERY scans slots
//             0 .. node_count-1 and returns one rsp_ch beat.
//   rsp_ch  : found, nearest_index (lowest on ties), distance_squared.
//             found=0 with zero fields when node_count is 0.
//   csr_ch  : writes node_count (values above 256 act as 256); always ready.
// Scan:
//   A load is written into the table RAM at its request beat. A query reads
//   the table RAM one entry per cycle; each entry then passes the RAM read
//   register and three distance stages before it is compared.
//   An empty table skips the scan and answers from the output register.
// Reset clears node_count and all control state; table contents are kept
// and must be loaded before they are queried. When rsp_ch stalls, the result
// is held in the output register; loads are still taken, and a following
// query scans and then waits until the held beat is taken.
// ----------------------------------------------------------------------------
module nearest_point_search_top (
   input  logic  clock,
   input  logic  reset,
   nps_req_if.sink   req_ch,
   nps_rsp_if.source rsp_ch,
   nps_csr_if.sink   csr_ch
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_WAIT = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   logic [1:0]                   state_ff, state_in;
   logic [nps_pkg::COUNT_W-1:0]  node_count_ff, node_count_in;
   logic [nps_pkg::ADDR_W-1:0]   addr_ff, addr_in, last_ff, last_in;
   nps_pkg::coord_type           qx_ff, qx_in, qz_ff, qz_in;
   nps_pkg::dist_tag_type        rd_tag_ff, rd_tag_in;
   logic                         have_ff, have_in;
   logic [nps_pkg::ADDR_W-1:0]   best_i_ff, best_i_in;
   logic [nps_pkg::DIST_W-1:0]   best_d_ff, best_d_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_found_ff, rsp_found_in;
   logic [nps_pkg::INDEX_W-1:0]  rsp_index_ff, rsp_index_in;
   logic [nps_pkg::DIST_W-1:0]   rsp_dist_ff, rsp_dist_in;

   logic [nps_pkg::COUNT_W-1:0]  count_eff;
   logic                         req_beat;
   logic                         ram_wr_en;
   logic                         ram_rd_en;
   logic [nps_pkg::POINT_W-1:0]  ram_rd_data;
   nps_pkg::dist_tag_type        dist_tag;
   logic [nps_pkg::DIST_W-1:0]   dist_val;
   logic                         out_free;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;
   assign req_beat     = req_ch.valid && req_ch.ready;
   assign ram_wr_en    = req_beat && (req_ch.operation == nps_pkg::OP_LOAD);
   assign ram_rd_en    = (state_ff == ST_SCAN);
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign count_eff    = (node_count_ff > nps_pkg::COUNT_W'(nps_pkg::MAX_ENTRIES))
                         ? nps_pkg::COUNT_W'(nps_pkg::MAX_ENTRIES) : node_count_ff;

   nps_ram #(
      .WIDTH (nps_pkg::POINT_W),
      .DEPTH (nps_pkg::MAX_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (nps_pkg::ADDR_W'(req_ch.entry_index)),
      .wr_data ({req_ch.pos_x, req_ch.pos_z}),
      .rd_en   (ram_rd_en),
      .rd_addr (addr_ff),
      .rd_data (ram_rd_data)
   );

   nps_dist u_dist (
      .clock    (clock),
      .reset    (reset),
      .tag      (rd_tag_ff),
      .point_x  (ram_rd_data[nps_pkg::POINT_W-1:nps_pkg::COORD_BITS]),
      .point_z  (ram_rd_data[nps_pkg::COORD_BITS-1:0]),
      .query_x  (qx_ff),
      .query_z  (qz_ff),
      .out_tag  (dist_tag),
      .out_dist (dist_val)
   );

   always_comb begin
      state_in      = state_ff;
      node_count_in = node_count_ff;
      addr_in       = addr_ff;
      last_in       = last_ff;
      qx_in         = qx_ff;
      qz_in         = qz_ff;
      have_in       = have_ff;
      best_i_in     = best_i_ff;
      best_d_in     = best_d_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_found_in  = rsp_found_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_dist_in   = rsp_dist_ff;
      rd_tag_in     = '0;

      if (csr_ch.valid && csr_ch.ready) begin
         node_count_in = csr_ch.node_count;
      end

      // keep the nearest so far; strictly less keeps the lowest index
      if (dist_tag.valid && (!have_ff || dist_val < best_d_ff)) begin
         have_in   = 1'b1;
         best_i_in = dist_tag.index;
         best_d_in = dist_val;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat && req_ch.operation == nps_pkg::OP_QUERY) begin
               qx_in   = req_ch.pos_x;
               qz_in   = req_ch.pos_z;
               have_in = 1'b0;
               addr_in = '0;
               last_in = nps_pkg::ADDR_W'(count_eff - nps_pkg::COUNT_W'(1));
               state_in = (count_eff == '0) ? ST_OUT : ST_SCAN;
            end
         end
         ST_SCAN: begin
            rd_tag_in.valid = 1'b1;
            rd_tag_in.last  = (addr_ff == last_ff);
            rd_tag_in.index = addr_ff;
            addr_in = addr_ff + nps_pkg::ADDR_W'(1);
            if (addr_ff == last_ff) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (dist_tag.valid && dist_tag.last) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = have_ff;
               rsp_index_in = have_ff ? nps_pkg::INDEX_W'(best_i_ff) : '0;
               rsp_dist_in  = have_ff ? best_d_ff : '0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         node_count_ff <= '0;
         rd_tag_ff     <= '0;
         have_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         node_count_ff <= node_count_in;
         rd_tag_ff     <= rd_tag_in;
         have_ff       <= have_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      addr_ff      <= addr_in;
      last_ff      <= last_in;
      qx_ff        <= qx_in;
      qz_ff        <= qz_in;
      best_i_ff    <= best_i_in;
      best_d_ff    <= best_d_in;
      rsp_found_ff <= rsp_found_in;
      rsp_index_ff <= rsp_index_in;
      rsp_dist_ff  <= rsp_dist_in;
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.found            = rsp_found_ff;
   assign rsp_ch.nearest_index    = rsp_index_ff;
   assign rsp_ch.distance_squared = rsp_dist_ff;

endmodule

### src/nps_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest point search checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module nps_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        req_operation,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        rsp_found,
   input logic [nps_pkg::INDEX_W-1:0] rsp_index,
   input logic [nps_pkg::DIST_W-1:0]  rsp_dist
);

   // hold a stalled response beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response beat dropped while stalled");

   // no response beat right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_index == '0 && rsp_dist == '0)
      else $error("empty-table response carries nonzero fields");

   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_operation == nps_pkg::OP_LOAD && !rsp_valid
      |=> !rsp_valid)
      else $error("load beat produced a response");

   a_query_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_operation == nps_pkg::OP_QUERY
      |=> !rsp_valid || !req_ready)
      else $error("query accepted without entering its scan");

endmodule

bind nearest_point_search_top nps_checker u_nps_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .req_operation (req_ch.operation),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_found     (rsp_ch.found),
   .rsp_index     (rsp_ch.nearest_index),
   .rsp_dist      (rsp_ch.distance_squared)
);

### tb/tb_nearest_point_search_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest point search testbench
// Loads points into the table, sets node_count while the block is idle, and
// sends queries. A scoreboard predicts each response with its own linear scan
// over a copy of the table and compares every response beat field by field.
// The request source idles and the response sink stalls at random.
// ----------------------------------------------------------------------------
module tb_nearest_point_search_top;

   localparam int PERIOD_NS     = 10;
   localparam int CYCLE_LIMIT   = 2000000;
   localparam int RANDOM_ITEMS  = 900;
   localparam int SETTLE_CYCLES = 16;

   localparam nps_pkg::coord_type COORD_MAX = {1'b0, {(nps_pkg::COORD_BITS-1){1'b1}}};
   localparam nps_pkg::coord_type COORD_MIN = {1'b1, {(nps_pkg::COORD_BITS-1){1'b0}}};

   typedef enum int {STYLE_WIDE, STYLE_CLUSTER, STYLE_CORNER} coord_style_type;
   typedef enum int {SINK_STEADY, SINK_LIGHT, SINK_HEAVY} sink_mode_type;

   typedef struct packed {
      logic                        found;
      logic [nps_pkg::INDEX_W-1:0] nearest_index;
      logic [nps_pkg::DIST_W-1:0]  distance_squared;
   } answer_type;

   class nearest_scoreboard;
      nps_pkg::coord_type          table_x [nps_pkg::MAX_ENTRIES];
      nps_pkg::coord_type          table_z [nps_pkg::MAX_ENTRIES];
      logic [nps_pkg::COUNT_W-1:0] node_count = '0;
      answer_type                  pending [$];
      int                          errors = 0;

      function void set_node_count(logic [nps_pkg::COUNT_W-1:0] value);
         node_count = value;
      endfunction

      function void note_request(logic operation, logic [nps_pkg::INDEX_W-1:0] entry_index,
                                 nps_pkg::coord_type pos_x, nps_pkg::coord_type pos_z);
         int                         span;
         longint                     dx;
         longint                     dz;
         logic [nps_pkg::DIST_W-1:0] sq_dist;
         answer_type                 best;
         if (operation == nps_pkg::OP_LOAD) begin
            table_x[entry_index] = pos_x;
            table_z[entry_index] = pos_z;
            return;
         end
         span = (node_count > nps_pkg::MAX_ENTRIES) ? nps_pkg::MAX_ENTRIES
                                                    : int'(node_count);
         best = '0;
         for (int i = 0; i < span; i++) begin
            dx = longint'(table_x[i]) - longint'(pos_x);
            dz = longint'(table_z[i]) - longint'(pos_z);
            sq_dist = nps_pkg::DIST_W'(dx * dx + dz * dz);
            if (!best.found || sq_dist < best.distance_squared) begin
               best.found            = 1'b1;
               best.nearest_index    = nps_pkg::INDEX_W'(i);
               best.distance_squared = sq_dist;
            end
         end
         pending = {pending, best};
      endfunction

      function void check_answer(logic found, logic [nps_pkg::INDEX_W-1:0] nearest_index,
                                 logic [nps_pkg::DIST_W-1:0] distance_squared);
         answer_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected response beat found=%0b index=%0d dist=%0d",
                     $time, found, nearest_index, distance_squared);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (found !== want.found) begin
            $display("%0t: found expected %0b actual %0b", $time, want.found, found);
            errors++;
         end
         if (nearest_index !== want.nearest_index) begin
            $display("%0t: nearest_index expected %0d actual %0d",
                     $time, want.nearest_index, nearest_index);
            errors++;
         end
         if (distance_squared !== want.distance_squared) begin
            $display("%0t: distance_squared expected %0d actual %0d",
                     $time, want.distance_squared, distance_squared);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   nps_req_if req_ch ();
   nps_rsp_if rsp_ch ();
   nps_csr_if csr_ch ();

   nearest_point_search_top u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   nearest_scoreboard  board;
   sink_mode_type      sink_mode    = SINK_LIGHT;
   bit                 source_gaps  = 1'b1;
   int                 sent_items   = 0;
   int                 cycle_count  = 0;
   bit                 loaded [nps_pkg::MAX_ENTRIES];
   nps_pkg::coord_type shadow_x [nps_pkg::MAX_ENTRIES];
   nps_pkg::coord_type shadow_z [nps_pkg::MAX_ENTRIES];

   always #(PERIOD_NS / 2) clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_ch.valid && csr_ch.ready)
            board.set_node_count(csr_ch.node_count);
         if (req_ch.valid && req_ch.ready)
            board.note_request(req_ch.operation, req_ch.entry_index,
                               req_ch.pos_x, req_ch.pos_z);
         if (rsp_ch.valid && rsp_ch.ready)
            board.check_answer(rsp_ch.found, rsp_ch.nearest_index,
                               rsp_ch.distance_squared);
      end
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(99);
      if (roll < 60)
         return 0;
      if (roll < 92)
         return $urandom_range(3, 1);
      return $urandom_range(40, 4);
   endfunction

   function automatic nps_pkg::coord_type pick_coord(coord_style_type style,
                                                     nps_pkg::coord_type center);
      case (style)
         STYLE_CLUSTER:
            return center + nps_pkg::coord_type'(int'($urandom_range(600)) - 300);
         STYLE_CORNER: begin
            case ($urandom_range(6))
               0: return COORD_MAX;
               1: return COORD_MIN;
               2: return '0;
               3: return nps_pkg::coord_type'(1);
               4: return nps_pkg::coord_type'(-1);
               5: return COORD_MAX - 1;
               default: return COORD_MIN + 1;
            endcase
         end
         default: return nps_pkg::coord_type'($urandom);
      endcase
   endfunction

   function automatic logic [nps_pkg::COUNT_W-1:0] pick_node_count();
      case ($urandom_range(9))
         0: return '0;
         1: return nps_pkg::COUNT_W'(nps_pkg::MAX_ENTRIES);
         2: return nps_pkg::COUNT_W'($urandom_range(511, nps_pkg::MAX_ENTRIES + 1));
         3, 4: return nps_pkg::COUNT_W'($urandom_range(64, 17));
         default: return nps_pkg::COUNT_W'($urandom_range(16, 1));
      endcase
   endfunction

   // random ready with stall bursts
   initial begin : response_sink
      int hold;
      hold = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold > 0) begin
            hold--;
            rsp_ch.ready <= 1'b0;
         end else if (sink_mode != SINK_STEADY &&
                      $urandom_range(99) < (sink_mode == SINK_HEAVY ? 40 : 15)) begin
            hold = pick_gap();
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   task automatic send_beat(logic operation, logic [nps_pkg::INDEX_W-1:0] entry_index,
                            nps_pkg::coord_type pos_x, nps_pkg::coord_type pos_z);
      int gap;
      gap = source_gaps ? pick_gap() : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.operation   <= operation;
      req_ch.entry_index <= entry_index;
      req_ch.pos_x       <= pos_x;
      req_ch.pos_z       <= pos_z;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (operation == nps_pkg::OP_LOAD) begin
         loaded[entry_index]   = 1'b1;
         shadow_x[entry_index] = pos_x;
         shadow_z[entry_index] = pos_z;
      end
      sent_items++;
   endtask

   task automatic load_point(logic [nps_pkg::INDEX_W-1:0] entry_index,
                             nps_pkg::coord_type pos_x, nps_pkg::coord_type pos_z);
      send_beat(nps_pkg::OP_LOAD, entry_index, pos_x, pos_z);
   endtask

   task automatic query_point(nps_pkg::coord_type pos_x, nps_pkg::coord_type pos_z);
      send_beat(nps_pkg::OP_QUERY,
                nps_pkg::INDEX_W'($urandom_range(nps_pkg::MAX_ENTRIES - 1)), pos_x, pos_z);
   endtask

   // hold the source until every response is back and the block is quiet
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_node_count(logic [nps_pkg::COUNT_W-1:0] value);
      drain();
      csr_ch.valid      <= 1'b1;
      csr_ch.node_count <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic fill_table(int span);
      for (int i = 0; i < span; i++)
         if (!loaded[i])
            load_point(nps_pkg::INDEX_W'(i), nps_pkg::coord_type'($urandom),
                       nps_pkg::coord_type'($urandom));
   endtask

   task automatic run_phase(logic [nps_pkg::COUNT_W-1:0] count);
      int                 span;
      int                 beats;
      int                 slot;
      int                 src;
      coord_style_type    style;
      nps_pkg::coord_type center;
      write_node_count(count);
      span = (count > nps_pkg::MAX_ENTRIES) ? nps_pkg::MAX_ENTRIES : int'(count);
      fill_table(span);
      style       = coord_style_type'($urandom_range(2));
      center      = nps_pkg::coord_type'($urandom);
      source_gaps = ($urandom_range(3) != 0);
      sink_mode   = sink_mode_type'($urandom_range(2));
      beats       = (span > 32) ? $urandom_range(10, 6) : $urandom_range(40, 20);
      repeat (beats) begin
         if ($urandom_range(99) < 35) begin
            slot = (span > 0 && $urandom_range(3) != 0)
                   ? $urandom_range(span - 1) : $urandom_range(nps_pkg::MAX_ENTRIES - 1);
            if (span > 0 && $urandom_range(4) == 0) begin
               // copy a live point to force a distance tie
               src = $urandom_range(span - 1);
               load_point(nps_pkg::INDEX_W'(slot), shadow_x[src], shadow_z[src]);
            end else begin
               load_point(nps_pkg::INDEX_W'(slot), pick_coord(style, center),
                          pick_coord(style, center));
            end
         end else if (span > 0 && $urandom_range(4) == 0) begin
            src = $urandom_range(span - 1);
            query_point(shadow_x[src], shadow_z[src]);
         end else begin
            query_point(pick_coord(style, center), pick_coord(style, center));
         end
         if ($urandom_range(99) < 3)
            drain();
      end
   endtask

   initial begin : stimulus
      int phase;
      int directed_items;
      board                = new();
      reset                = 1'b1;
      req_ch.valid         = 1'b0;
      req_ch.operation     = nps_pkg::OP_LOAD;
      req_ch.entry_index   = '0;
      req_ch.pos_x         = '0;
      req_ch.pos_z         = '0;
      csr_ch.valid         = 1'b0;
      csr_ch.node_count    = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // empty table straight out of reset
      query_point(COORD_MAX, COORD_MIN);
      load_point(8'd0, COORD_MAX, COORD_MIN);
      load_point(8'd1, COORD_MIN, COORD_MAX);
      load_point(8'd2, '0, '0);
      load_point(8'd3, '0, '0);
      load_point(8'd4, nps_pkg::coord_type'(-1), nps_pkg::coord_type'(1));
      write_node_count('0);
      query_point('0, '0);
      write_node_count(nps_pkg::COUNT_W'(1));
      query_point(COORD_MIN, COORD_MAX);
      query_point(COORD_MAX, COORD_MIN);
      write_node_count(nps_pkg::COUNT_W'(5));
      query_point('0, '0);
      query_point(COORD_MAX, COORD_MAX);
      query_point(COORD_MIN, COORD_MIN);
      query_point(nps_pkg::coord_type'(-1), '0);
      load_point(8'd255, COORD_MAX, COORD_MAX);
      load_point(8'd0, '0, '0);
      query_point('0, '0);
      directed_items = sent_items;

      phase = 0;
      while (sent_items < directed_items + RANDOM_ITEMS) begin
         if (phase == 0)
            run_phase(nps_pkg::COUNT_W'(nps_pkg::MAX_ENTRIES));
         else if (phase == 1)
            run_phase({nps_pkg::COUNT_W{1'b1}});
         else
            run_phase(pick_node_count());
         phase++;
      end

      drain();
      if (board.errors == 0 && board.pending.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

### nearest_point_search_top.f
src/nps_pkg.sv
src/nps_if.sv
src/nps_ram.sv
src/nps_dist.sv
src/nearest_point_search_top.sv
src/nps_checker.sv
tb/tb_nearest_point_search_top.sv
